// ===== sv/biu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the bilinear image upscaler.
// Used by the top module bilinear_image_upscaler; depends on nothing.
package biu_pkg;

    localparam int IDX_W      = 11;
    localparam int PIX_W      = 8;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int FAC_REG_W  = 4;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_SRC_WIDTH    = 2'd0;
    localparam cfg_index_t CFG_SRC_HEIGHT   = 2'd1;
    localparam cfg_index_t CFG_SCALE_FACTOR = 2'd2;

    localparam logic [CFG_DATA_W-1:0] SRC_WIDTH_RESET  = 9'd256;
    localparam logic [CFG_DATA_W-1:0] SRC_HEIGHT_RESET = 9'd256;
    localparam logic [FAC_REG_W-1:0]  SCALE_RESET      = 4'd2;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic             func;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [PIX_W-1:0] pixel_in;
    } biu_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             out_of_range;
    } biu_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_ACC,
        ST_DONE
    } biu_state_t;

endpackage

// ===== sv/biu_div.sv =====
`timescale 1ns / 1ps
// Iterative unsigned divider, two quotient bits per cycle.
// Standalone; the caller guarantees that the quotient fits in QUO_W bits.
module biu_div #(
    parameter int NUM_W = 35,
    parameter int DEN_W = 11,
    parameter int QUO_W = 24
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [QUO_W-1:0] quo
);

    localparam int ITER  = (QUO_W + 1) / 2;
    localparam int QW2   = 2 * ITER;
    localparam int EXT_W = NUM_W + QW2;
    localparam int CNT_W = $clog2(ITER + 1);

    logic [EXT_W-1:0] ext;
    logic [DEN_W-1:0] rem_reg, rem_next, den_reg, s1;
    logic [QW2-1:0]   low_reg, quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [DEN_W:0]   r1, r2, d1, d2;
    logic             ge1, ge2;

    // The bits above the quotient window are already below the divisor.
    assign ext = EXT_W'(num);

    always_comb begin
        r1 = {rem_reg, low_reg[QW2-1]};
        d1 = r1 - {1'b0, den_reg};
        ge1 = (r1 >= {1'b0, den_reg});
        s1 = ge1 ? d1[DEN_W-1:0] : r1[DEN_W-1:0];
        r2 = {s1, low_reg[QW2-2]};
        d2 = r2 - {1'b0, den_reg};
        ge2 = (r2 >= {1'b0, den_reg});
        rem_next = ge2 ? d2[DEN_W-1:0] : r2[DEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(ITER);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg <= den;
            rem_reg <= DEN_W'(ext[EXT_W-1:QW2]);
            low_reg <= ext[QW2-1:0];
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[QW2-3:0], 2'b00};
            quo_reg <= {quo_reg[QW2-3:0], ge1, ge2};
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg[QUO_W-1:0];

    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (rem_reg < den_reg))
        else $error("divider partial remainder not below divisor");

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg)
        else $error("divider did not go busy after start");

    a_idle_count: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (cnt_reg == '0))
        else $error("divider count nonzero while idle");

endmodule

// ===== sv/biu_frame.sv =====
`timescale 1ns / 1ps
// Frame store: one write port, one read port, registered read data.
// Standalone; contents are undefined until written.
module biu_frame #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16,
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/bilinear_image_upscaler.sv =====
`timescale 1ns / 1ps
// Load item: a new item can be taken every cycle while no query is in flight.
// Query item: the sequencer steps through the multiply, divider start, divide, accumulate
// and done states; the time to the result is set by the two-bit-per-cycle divider and the
// four serial frame-store reads. An out-of-range query goes straight to the done state.
// One query is in flight at a time; input is free again once the result enters m_data.
// Reset (synchronous, active low) restores the three configuration registers; the frame store is not cleared.
module bilinear_image_upscaler #(
    parameter int MAX_DIM     = 256,
    parameter int MAX_FACTOR  = 8,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  biu_pkg::biu_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output biu_pkg::biu_out_t                   m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  biu_pkg::cfg_index_t                 cfg_index,
    input  logic [biu_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import biu_pkg::*;

    localparam int WB       = WEIGHT_BITS;
    localparam int DIM_BITS = $clog2(MAX_DIM);
    localparam int DIM_W    = $clog2(MAX_DIM + 1);
    localparam int FAC_W    = $clog2(MAX_FACTOR + 1);
    localparam int HF_W     = $clog2(MAX_DIM * MAX_FACTOR + 1);
    localparam int DEN_W    = $clog2(MAX_DIM * MAX_FACTOR);
    localparam int NUM_W    = IDX_W + DIM_BITS;
    localparam int DVD_W    = NUM_W + WB;
    localparam int QUO_W    = DIM_BITS + WB;
    localparam int WP_W     = 2 * WB + 1;
    localparam int ACC_W    = PIX_W + 2 * WB;
    localparam int ADDR_W   = $clog2(MAX_DIM * MAX_DIM);
    localparam int CW0      = (HF_W > IDX_W) ? HF_W : IDX_W;
    localparam int CW       = ((CW0 > CFG_DATA_W) ? CW0 : CFG_DATA_W) + 1;
    localparam logic [2:0]  ACC_LAST = 3'd5;
    localparam logic [WB:0] ONE      = {1'b1, {WB{1'b0}}};

    biu_state_t state_reg, state_next;

    logic [CFG_DATA_W-1:0] cfg_width_reg, cfg_height_reg;
    logic [FAC_REG_W-1:0]  cfg_scale_reg;
    logic [DIM_W-1:0]      w_eff, h_eff;
    logic [FAC_W-1:0]      f_eff;
    logic [HF_W-1:0]       hf_w, hf_h;
    logic                  query_oor, load_ok, in_accept;

    logic [IDX_W-1:0]      row_reg, col_reg;
    logic                  oor_reg;
    logic [NUM_W-1:0]      num_row_reg, num_col_reg;
    logic [DEN_W-1:0]      den_row_reg, den_col_reg;
    logic                  div_start, busy_row, busy_col;
    logic [QUO_W-1:0]      quo_row, quo_col;
    logic [DIM_W-1:0]      xp, yp;

    logic [DIM_BITS-1:0]   x_reg, x1_reg, y_reg, y1_reg, rd_r, rd_c;
    logic [WB-1:0]         u_reg, v_reg;
    logic [WB:0]           wrow, wcol;
    logic [2:0]            cnt_reg;
    logic                  v1_reg, v2_reg;
    logic [WP_W-1:0]       wprod_reg;
    logic [ACC_W-1:0]      term_reg, acc_reg;

    logic                  mem_wr_en, rd_en, out_load;
    logic [ADDR_W-1:0]     wr_addr, rd_addr;
    logic [PIX_W-1:0]      rd_data;

    logic                  m_valid_reg;
    biu_out_t              m_data_reg, result;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [DIM_BITS-1:0] r,
                                                   input logic [DIM_BITS-1:0] c);
        return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_DIM)) + ADDR_W'(c);
    endfunction

    // Configuration registers keep the written bits (scale factor: low four bits only); use is saturated.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg  <= SRC_WIDTH_RESET;
            cfg_height_reg <= SRC_HEIGHT_RESET;
            cfg_scale_reg  <= SCALE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_SRC_WIDTH:    cfg_width_reg  <= cfg_data;
                CFG_SRC_HEIGHT:   cfg_height_reg <= cfg_data;
                CFG_SCALE_FACTOR: cfg_scale_reg  <= cfg_data[FAC_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (CW'(cfg_width_reg) < CW'(2)) begin
            w_eff = DIM_W'(2);
        end else if (CW'(cfg_width_reg) > CW'(MAX_DIM)) begin
            w_eff = DIM_W'(MAX_DIM);
        end else begin
            w_eff = DIM_W'(cfg_width_reg);
        end
        if (CW'(cfg_height_reg) < CW'(2)) begin
            h_eff = DIM_W'(2);
        end else if (CW'(cfg_height_reg) > CW'(MAX_DIM)) begin
            h_eff = DIM_W'(MAX_DIM);
        end else begin
            h_eff = DIM_W'(cfg_height_reg);
        end
        if (CW'(cfg_scale_reg) < CW'(1)) begin
            f_eff = FAC_W'(1);
        end else if (CW'(cfg_scale_reg) > CW'(MAX_FACTOR)) begin
            f_eff = FAC_W'(MAX_FACTOR);
        end else begin
            f_eff = FAC_W'(cfg_scale_reg);
        end
    end

    assign hf_w = HF_W'(HF_W'(w_eff) * HF_W'(f_eff));
    assign hf_h = HF_W'(HF_W'(h_eff) * HF_W'(f_eff));

    assign query_oor = (CW'(s_data.row) >= CW'(hf_h)) || (CW'(s_data.col) >= CW'(hf_w));
    assign load_ok   = (CW'(s_data.row) < CW'(h_eff)) && (CW'(s_data.col) < CW'(w_eff));
    assign in_accept = s_valid && s_ready;

    assign mem_wr_en = in_accept && (s_data.func == FUNC_LOAD) && load_ok;
    assign wr_addr   = addr_of(DIM_BITS'(s_data.row), DIM_BITS'(s_data.col));

    // Control sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        div_start  = 1'b0;
        rd_en      = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && (s_data.func == FUNC_QUERY)) begin
                    state_next = query_oor ? ST_DONE : ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_START;
            end
            ST_START: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (!busy_row && !busy_col) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                rd_en = !cnt_reg[2];
                if (cnt_reg == ACC_LAST) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Numerator idx*(dim-1) and denominator dim*factor-1 for each axis.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            row_reg <= s_data.row;
            col_reg <= s_data.col;
            oor_reg <= query_oor;
        end
        if (state_reg == ST_MUL) begin
            num_row_reg <= NUM_W'(NUM_W'(row_reg) * NUM_W'(h_eff - DIM_W'(1)));
            num_col_reg <= NUM_W'(NUM_W'(col_reg) * NUM_W'(w_eff - DIM_W'(1)));
            den_row_reg <= DEN_W'(hf_h - HF_W'(1));
            den_col_reg <= DEN_W'(hf_w - HF_W'(1));
        end
    end

    // Quotient of (num << WB) / den holds the integer part above the weight.
    biu_div #(
        .NUM_W (DVD_W),
        .DEN_W (DEN_W),
        .QUO_W (QUO_W)
    ) u_div_row (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     ({num_row_reg, {WB{1'b0}}}),
        .den     (den_row_reg),
        .busy    (busy_row),
        .quo     (quo_row)
    );

    biu_div #(
        .NUM_W (DVD_W),
        .DEN_W (DEN_W),
        .QUO_W (QUO_W)
    ) u_div_col (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     ({num_col_reg, {WB{1'b0}}}),
        .den     (den_col_reg),
        .busy    (busy_col),
        .quo     (quo_col)
    );

    assign xp = DIM_W'(quo_row[QUO_W-1:WB]) + DIM_W'(1);
    assign yp = DIM_W'(quo_col[QUO_W-1:WB]) + DIM_W'(1);

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_DIV) && !busy_row && !busy_col) begin
            x_reg  <= quo_row[QUO_W-1:WB];
            y_reg  <= quo_col[QUO_W-1:WB];
            u_reg  <= quo_row[WB-1:0];
            v_reg  <= quo_col[WB-1:0];
            // The far neighbor is clamped to the last row and column.
            x1_reg <= DIM_BITS'((xp < h_eff) ? xp : (h_eff - DIM_W'(1)));
            y1_reg <= DIM_BITS'((yp < w_eff) ? yp : (w_eff - DIM_W'(1)));
        end
    end

    // Four corner reads, each followed by a weight multiply and an accumulate.
    // Bit 0 of the corner number picks the lower row, bit 1 the right column.
    assign rd_r    = cnt_reg[0] ? x1_reg : x_reg;
    assign rd_c    = cnt_reg[1] ? y1_reg : y_reg;
    assign rd_addr = addr_of(rd_r, rd_c);
    assign wrow    = cnt_reg[0] ? {1'b0, u_reg} : (ONE - {1'b0, u_reg});
    assign wcol    = cnt_reg[1] ? {1'b0, v_reg} : (ONE - {1'b0, v_reg});

    biu_frame #(
        .DEPTH  (MAX_DIM * MAX_DIM),
        .ADDR_W (ADDR_W),
        .DATA_W (PIX_W)
    ) u_frame (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_data.pixel_in),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
        end else begin
            cnt_reg <= (state_reg == ST_ACC) ? cnt_reg + 3'd1 : 3'd0;
            v1_reg  <= rd_en;
            v2_reg  <= v1_reg;
        end
    end

    // The sum is held through the done state, where the result may wait on the output.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            wprod_reg <= WP_W'(wrow * wcol);
        end
        if (v1_reg) begin
            term_reg <= ACC_W'(rd_data * wprod_reg);
        end
        if ((state_reg != ST_ACC) && (state_reg != ST_DONE)) begin
            acc_reg <= '0;
        end else if (v2_reg) begin
            acc_reg <= acc_reg + term_reg;
        end
    end

    // The weights sum to exactly one, so the top bits never exceed full scale.
    always_comb begin
        if (oor_reg) begin
            result.pixel_out    = '0;
            result.out_of_range = 1'b1;
        end else begin
            result.pixel_out    = acc_reg[ACC_W-1:2*WB];
            result.out_of_range = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_query_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && (s_data.func == FUNC_QUERY)) |=> (state_reg != ST_IDLE))
        else $error("accepted query did not start work");

    a_write_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |-> (state_reg == ST_IDLE))
        else $error("frame store written while a query is in flight");

    a_neighbors_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ACC) |-> ((DIM_W'(x1_reg) < h_eff) && (DIM_W'(y1_reg) < w_eff)))
        else $error("neighbor index outside the source image");

    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.out_of_range) |-> (m_data_reg.pixel_out == '0))
        else $error("out-of-range result carries a nonzero pixel");

endmodule
